// File: src/arc_pkg.sv
`default_nettype none
package arc_pkg;
    localparam int FRAME_COUNT = 64;
    localparam int SLOTS = 2 * FRAME_COUNT;
    localparam int SW = $clog2(SLOTS);
    localparam int FW = 6;
    localparam int CW = 7;
    localparam int PW = 31;
    localparam int STW = 32;

    localparam logic [2:0] L_FREE = 3'd0;
    localparam logic [2:0] L_T1 = 3'd1;
    localparam logic [2:0] L_T2 = 3'd2;
    localparam logic [2:0] L_B1 = 3'd3;
    localparam logic [2:0] L_B2 = 3'd4;

    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_SET_EVICT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_EVICT = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_PINNED = 2'd2;

    typedef struct packed {
        logic [PW-1:0] page;
        logic [FW-1:0] frame;
        logic [2:0] list;
        logic pinned_off;
        logic [STW-1:0] stamp;
    } entry_t;
endpackage
`default_nettype wire

// File: src/arc_page_replacer.sv
`default_nettype none
// Adaptive replacement policy for a buffer pool of up to 64 frames. Pages, frames, stamps,
// list codes and pin bits sit in synchronous entry memories of 2*FRAME_COUNT slots that are
// swept one slot per cycle. After reset a clearing pass frees every slot, and s_tready stays
// low until it ends. Set evictable, remove and an access to a live frame need one sweep;
// evict also reads the victim's frame back when there is one; a ghost hit adds a restoring
// divide (skipped when the divisor is zero); and a miss needs a second sweep. The response
// must be taken before the next request is accepted, and one response comes for every
// request.
module arc_page_replacer
    import arc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [0:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input wire logic s_tvalid,
    output logic s_tready,
    // cmd[1:0], frame_index[7:2], page_number[38:8], make_evictable[39]
    input wire logic [39:0] s_tdata,
    output logic m_tvalid,
    input wire logic m_tready,
    // victim_valid[0], victim_frame[6:1], evictable_count[13:7], status[15:14]
    output logic [15:0] m_tdata
);
    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2, S_DIV = 4'd3,
        S_SCAN2 = 4'd4, S_APPLY = 4'd5, S_OUT = 4'd6, S_VREAD = 4'd7, S_VCAP = 4'd8,
        S_CLR = 4'd9;
    localparam int XW = SW + 1;

    logic [PW-1:0] mem_page [SLOTS];
    logic [FW-1:0] mem_frame [SLOTS];
    logic [STW-1:0] mem_stamp [SLOTS];
    logic [2:0] mem_list [SLOTS];
    logic mem_poff [SLOTS];

    logic [3:0] state_reg;
    logic [CW-1:0] cap_reg, p_reg, tot_reg;
    logic [STW-1:0] ctr_reg;
    logic [1:0] cmd_reg;
    logic [FW-1:0] f_reg;
    logic [PW-1:0] pg_reg;
    logic mk_reg;
    logic [XW-1:0] idx_reg;
    logic rd_v_reg;
    logic [SW-1:0] rd_i_reg;
    logic [PW-1:0] rd_page;
    logic [FW-1:0] rd_frame;
    logic [STW-1:0] rd_stamp;
    logic [2:0] rd_list;
    logic rd_poff;

    logic [XW-1:0] n1_reg, n2_reg, nb1_reg, nb2_reg;
    logic live_hit_reg, ghost_hit_reg, free_hit_reg;
    logic [SW-1:0] live_i_reg, ghost_i_reg, free_i_reg;
    logic live_poff_reg, ghost_b1_reg, o0_poff_reg;
    logic [STW-1:0] ghost_age_reg;
    // oldest trackers: 0 T1 any,1 B1,2 B2,3 T1 unpinned,4 T2 unpinned
    logic [4:0] o_v_reg;
    logic [SW-1:0] o_i_reg [5];
    logic [STW-1:0] o_a_reg [5];
    logic [FW-1:0] vframe_reg;
    logic vvalid_reg;
    logic [1:0] st_reg;
    logic [XW-1:0] div_n_reg, div_d_reg, div_q_reg, div_r_reg;
    logic [3:0] div_c_reg;
    logic drop_v_reg;
    logic [SW-1:0] drop_i_reg;

    logic [CW-1:0] ceff;
    assign ceff = (cap_reg == '0) ? CW'(1) : (cap_reg > CW'(FRAME_COUNT)) ?
        CW'(FRAME_COUNT) : cap_reg;

    logic f_out;
    assign f_out = (int'(f_reg) >= FRAME_COUNT);

    assign pready = 1'b1;
    assign prdata = {25'd0, cap_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {st_reg, tot_reg, vframe_reg, vvalid_reg};

    logic [SW-1:0] rd_addr;
    assign rd_addr = idx_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        rd_page <= mem_page[rd_addr];
        rd_frame <= mem_frame[rd_addr];
        rd_stamp <= mem_stamp[rd_addr];
    end

    logic [2:0] rl;
    logic rp;
    logic [STW-1:0] age;
    assign rl = rd_list;
    assign rp = rd_poff;
    assign age = ctr_reg - rd_stamp;

    logic wr_en;
    logic [SW-1:0] wr_i;
    logic wr_pf;
    logic [PW-1:0] wr_page;
    logic [FW-1:0] wr_frame;

    logic ev_pref, t1_first_ok, ev_v;
    logic [SW-1:0] ev_i;
    logic [2:0] ev_g;
    assign ev_pref = (n1_reg != '0) && (n1_reg >= XW'(p_reg));
    assign t1_first_ok = ev_pref ? o_v_reg[3] : !o_v_reg[4];
    assign ev_v = o_v_reg[3] || o_v_reg[4];
    assign ev_i = t1_first_ok ? o_i_reg[3] : o_i_reg[4];
    assign ev_g = t1_first_ok ? L_B1 : L_B2;

    logic [XW-1:0] l1, tot_e;
    assign l1 = n1_reg + nb1_reg;
    assign tot_e = n1_reg + n2_reg + nb1_reg + nb2_reg;
    logic miss_slot_v;
    logic [SW-1:0] miss_slot;
    always_comb
    begin
        miss_slot_v = 1'b1;
        miss_slot = free_i_reg;
        if (!free_hit_reg)
        begin
            if (o_v_reg[2])
                miss_slot = o_i_reg[2];
            else if (o_v_reg[1])
                miss_slot = o_i_reg[1];
            else
                miss_slot_v = 1'b0;
        end
    end

    logic drop_now_v, drop_t1;
    logic [SW-1:0] drop_now_i;
    always_comb
    begin
        drop_now_v = 1'b0;
        drop_t1 = 1'b0;
        drop_now_i = o_i_reg[1];
        if (cmd_reg == CMD_ACCESS && !f_out && !live_hit_reg && !ghost_hit_reg)
        begin
            if (CW'(l1) == ceff && l1 <= XW'(FRAME_COUNT))
            begin
                if (CW'(n1_reg) < ceff)
                    drop_now_v = o_v_reg[1];
                else
                begin
                    drop_now_v = o_v_reg[0];
                    drop_t1 = 1'b1;
                    drop_now_i = o_i_reg[0];
                end
            end
            else if (l1 < XW'(ceff) && tot_e == {ceff, 1'b0})
            begin
                drop_now_v = o_v_reg[2];
                drop_now_i = o_i_reg[2];
            end
        end
    end

    logic lw_en, pw_en, lw_pd;
    logic [SW-1:0] lw_i;
    logic [2:0] lw_ld;
    always_comb
    begin
        lw_en = 1'b0;
        pw_en = 1'b0;
        lw_i = rd_addr;
        lw_ld = L_FREE;
        lw_pd = 1'b0;
        if (state_reg == S_CLR)
        begin
            lw_en = 1'b1;
            pw_en = 1'b1;
        end
        else if (state_reg == S_DEC)
        begin
            lw_en = drop_now_v;
            lw_i = drop_now_i;
        end
        else if (state_reg == S_APPLY)
        begin
            case (cmd_reg)
                CMD_ACCESS:
                begin
                    if (live_hit_reg)
                    begin
                        lw_en = 1'b1;
                        lw_i = live_i_reg;
                        lw_ld = L_T2;
                    end
                    else if (ghost_hit_reg)
                    begin
                        lw_en = 1'b1;
                        pw_en = 1'b1;
                        lw_i = ghost_i_reg;
                        lw_ld = L_T2;
                    end
                    else if (miss_slot_v)
                    begin
                        lw_en = 1'b1;
                        pw_en = 1'b1;
                        lw_i = miss_slot;
                        lw_ld = L_T1;
                    end
                end
                CMD_SET_EVICT:
                begin
                    lw_i = live_i_reg;
                    lw_pd = mk_reg;
                    pw_en = live_hit_reg && (live_poff_reg != mk_reg);
                end
                CMD_REMOVE:
                begin
                    lw_i = live_i_reg;
                    lw_en = live_hit_reg && live_poff_reg;
                    pw_en = live_hit_reg && live_poff_reg;
                end
                default:
                begin
                    lw_i = ev_i;
                    lw_ld = ev_g;
                    lw_en = ev_v;
                    pw_en = ev_v;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
            mem_list[lw_i] <= lw_ld;
        if (pw_en)
            mem_poff[lw_i] <= lw_pd;
        rd_list <= mem_list[rd_addr];
        rd_poff <= mem_poff[rd_addr];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_i = '0;
        wr_pf = 1'b0;
        wr_page = pg_reg;
        wr_frame = f_reg;
        if (state_reg == S_APPLY)
        begin
            if (cmd_reg == CMD_ACCESS)
            begin
                if (live_hit_reg)
                begin
                    wr_en = 1'b1;
                    wr_i = live_i_reg;
                    wr_pf = 1'b1;
                end
                else if (ghost_hit_reg)
                begin
                    wr_en = 1'b1;
                    wr_i = ghost_i_reg;
                    wr_pf = 1'b1;
                end
                else if (miss_slot_v)
                begin
                    wr_en = 1'b1;
                    wr_i = miss_slot;
                    wr_pf = 1'b1;
                end
                if (live_hit_reg)
                    wr_frame = rd_frame;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (!(live_hit_reg || ghost_hit_reg) || live_hit_reg)
                mem_page[wr_i] <= wr_page;
            if (!live_hit_reg)
                mem_frame[wr_i] <= wr_frame;
            if (wr_pf)
                mem_stamp[wr_i] <= ctr_reg;
        end
        else if (state_reg == S_APPLY && cmd_reg == CMD_EVICT && ev_v)
        begin
            mem_stamp[ev_i] <= ctr_reg;
        end
    end

    logic [XW-1:0] nxt_idx;
    assign nxt_idx = idx_reg + XW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cap_reg <= CW'(64);
            p_reg <= '0;
            tot_reg <= '0;
            ctr_reg <= '0;
            idx_reg <= '0;
            rd_v_reg <= 1'b0;
            rd_i_reg <= '0;
            cmd_reg <= '0;
            f_reg <= '0;
            pg_reg <= '0;
            mk_reg <= 1'b0;
            n1_reg <= '0;
            n2_reg <= '0;
            nb1_reg <= '0;
            nb2_reg <= '0;
            live_hit_reg <= 1'b0;
            ghost_hit_reg <= 1'b0;
            free_hit_reg <= 1'b0;
            live_i_reg <= '0;
            ghost_i_reg <= '0;
            free_i_reg <= '0;
            live_poff_reg <= 1'b0;
            ghost_b1_reg <= 1'b0;
            o0_poff_reg <= 1'b0;
            ghost_age_reg <= '0;
            o_v_reg <= '0;
            for (int k = 0; k < 5; k++)
            begin
                o_i_reg[k] <= '0;
                o_a_reg[k] <= '0;
            end
            vframe_reg <= '0;
            vvalid_reg <= 1'b0;
            st_reg <= ST_DONE;
            div_n_reg <= '0;
            div_d_reg <= '0;
            div_q_reg <= '0;
            div_r_reg <= '0;
            div_c_reg <= '0;
            drop_v_reg <= 1'b0;
            drop_i_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 1'b0)
                cap_reg <= pwdata[CW-1:0];
            unique case (state_reg)
                S_CLR:
                begin
                    idx_reg <= nxt_idx;
                    if (idx_reg == XW'(SLOTS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= s_tdata[1:0];
                        f_reg <= s_tdata[7:2];
                        pg_reg <= s_tdata[38:8];
                        mk_reg <= s_tdata[39];
                        idx_reg <= '0;
                        rd_v_reg <= 1'b0;
                        n1_reg <= '0;
                        n2_reg <= '0;
                        nb1_reg <= '0;
                        nb2_reg <= '0;
                        live_hit_reg <= 1'b0;
                        ghost_hit_reg <= 1'b0;
                        free_hit_reg <= 1'b0;
                        o_v_reg <= '0;
                        vvalid_reg <= 1'b0;
                        vframe_reg <= '0;
                        st_reg <= ST_DONE;
                        drop_v_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN, S_SCAN2:
                begin
                    rd_v_reg <= (idx_reg < XW'(SLOTS));
                    rd_i_reg <= rd_addr;
                    if (idx_reg < XW'(SLOTS))
                        idx_reg <= nxt_idx;
                    if (rd_v_reg && state_reg == S_SCAN)
                    begin
                        if (rl == L_T1) n1_reg <= n1_reg + XW'(1);
                        if (rl == L_T2) n2_reg <= n2_reg + XW'(1);
                        if (rl == L_B1) nb1_reg <= nb1_reg + XW'(1);
                        if (rl == L_B2) nb2_reg <= nb2_reg + XW'(1);
                        if (rl == L_FREE && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_i_reg <= rd_i_reg;
                        end
                        if ((rl == L_T1 || rl == L_T2) && rd_frame == f_reg && !live_hit_reg)
                        begin
                            live_hit_reg <= 1'b1;
                            live_i_reg <= rd_i_reg;
                            live_poff_reg <= rp;
                        end
                        if ((rl == L_B1 || rl == L_B2) && rd_page == pg_reg &&
                            (!ghost_hit_reg || age < ghost_age_reg))
                        begin
                            ghost_hit_reg <= 1'b1;
                            ghost_i_reg <= rd_i_reg;
                            ghost_age_reg <= age;
                            ghost_b1_reg <= (rl == L_B1);
                        end
                        for (int k = 0; k < 5; k++)
                        begin
                            if (((k == 0 && rl == L_T1) || (k == 1 && rl == L_B1) ||
                                 (k == 2 && rl == L_B2) || (k == 3 && rl == L_T1 && rp) ||
                                 (k == 4 && rl == L_T2 && rp)) &&
                                (!o_v_reg[k] || age > o_a_reg[k]))
                            begin
                                o_v_reg[k] <= 1'b1;
                                o_i_reg[k] <= rd_i_reg;
                                o_a_reg[k] <= age;
                                if (k == 0)
                                    o0_poff_reg <= rp;
                            end
                        end
                    end
                    if (rd_v_reg && state_reg == S_SCAN2)
                    begin
                        if (rl == L_FREE && !free_hit_reg)
                        begin
                            free_hit_reg <= 1'b1;
                            free_i_reg <= rd_i_reg;
                        end
                        if (((rl == L_B1) || (rl == L_B2)) && !(drop_v_reg &&
                            rd_i_reg == drop_i_reg))
                        begin
                            if (rl == L_B1 && (!o_v_reg[1] || age > o_a_reg[1]))
                            begin
                                o_v_reg[1] <= 1'b1;
                                o_i_reg[1] <= rd_i_reg;
                                o_a_reg[1] <= age;
                            end
                            if (rl == L_B2 && (!o_v_reg[2] || age > o_a_reg[2]))
                            begin
                                o_v_reg[2] <= 1'b1;
                                o_i_reg[2] <= rd_i_reg;
                                o_a_reg[2] <= age;
                            end
                        end
                    end
                    if (!rd_v_reg && idx_reg == XW'(SLOTS))
                        state_reg <= (state_reg == S_SCAN) ? S_DEC : S_APPLY;
                end
                S_DEC:
                begin
                    state_reg <= S_APPLY;
                    if (cmd_reg != CMD_EVICT && f_out)
                        st_reg <= ST_ABSENT;
                    if (cmd_reg != CMD_EVICT && f_out)
                        state_reg <= S_OUT;
                    else if (cmd_reg == CMD_ACCESS && !live_hit_reg && ghost_hit_reg)
                    begin
                        if (ghost_b1_reg)
                        begin
                            div_n_reg <= nb2_reg;
                            div_d_reg <= nb1_reg;
                        end
                        else
                        begin
                            div_n_reg <= nb1_reg;
                            div_d_reg <= nb2_reg;
                        end
                        div_q_reg <= '0;
                        div_r_reg <= '0;
                        div_c_reg <= 4'(XW);
                        state_reg <= S_DIV;
                    end
                    else if (cmd_reg == CMD_ACCESS && !live_hit_reg)
                    begin
                        drop_v_reg <= drop_now_v;
                        drop_i_reg <= drop_now_i;
                        if (drop_now_v && drop_t1 && o0_poff_reg && tot_reg != '0)
                            tot_reg <= tot_reg - CW'(1);
                        free_hit_reg <= 1'b0;
                        o_v_reg[2:1] <= 2'b00;
                        idx_reg <= '0;
                        rd_v_reg <= 1'b0;
                        state_reg <= S_SCAN2;
                    end
                end
                S_DIV:
                begin
                    if (div_d_reg == '0)
                    begin
                        div_q_reg <= XW'(1);
                        state_reg <= S_APPLY;
                    end
                    else if (div_c_reg == '0)
                        state_reg <= S_APPLY;
                    else
                    begin
                        logic [XW:0] r2;
                        r2 = {div_r_reg, div_n_reg[XW-1]};
                        div_n_reg <= {div_n_reg[XW-2:0], 1'b0};
                        div_c_reg <= div_c_reg - 4'd1;
                        if (r2 >= {1'b0, div_d_reg})
                        begin
                            div_r_reg <= XW'(r2 - {1'b0, div_d_reg});
                            div_q_reg <= {div_q_reg[XW-2:0], 1'b1};
                        end
                        else
                        begin
                            div_r_reg <= XW'(r2);
                            div_q_reg <= {div_q_reg[XW-2:0], 1'b0};
                        end
                    end
                end
                S_APPLY:
                begin
                    state_reg <= S_OUT;
                    unique case (cmd_reg)
                        CMD_ACCESS:
                        begin
                            if (live_hit_reg)
                                ctr_reg <= ctr_reg + STW'(1);
                            else if (ghost_hit_reg)
                            begin
                                logic [XW:0] d, sum;
                                d = (div_q_reg == '0) ? (XW+1)'(1) : {1'b0, div_q_reg};
                                if (ghost_b1_reg)
                                begin
                                    sum = (XW+1)'(p_reg) + d;
                                    p_reg <= (sum > (XW+1)'(ceff)) ? ceff : CW'(sum);
                                end
                                else
                                    p_reg <= ((XW+1)'(p_reg) > d) ? p_reg - CW'(d) : '0;
                                ctr_reg <= ctr_reg + STW'(1);
                            end
                            else if (miss_slot_v)
                                ctr_reg <= ctr_reg + STW'(1);
                        end
                        CMD_SET_EVICT:
                        begin
                            if (!live_hit_reg || live_poff_reg == mk_reg)
                                st_reg <= ST_ABSENT;
                            else
                            begin
                                if (mk_reg) tot_reg <= tot_reg + CW'(1);
                                else if (tot_reg != '0) tot_reg <= tot_reg - CW'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!live_hit_reg)
                                st_reg <= ST_ABSENT;
                            else if (!live_poff_reg)
                                st_reg <= ST_PINNED;
                            else if (tot_reg != '0)
                                tot_reg <= tot_reg - CW'(1);
                        end
                        default:
                        begin
                            if (!ev_v)
                                st_reg <= ST_ABSENT;
                            else
                            begin
                                ctr_reg <= ctr_reg + STW'(1);
                                if (tot_reg != '0) tot_reg <= tot_reg - CW'(1);
                                vvalid_reg <= 1'b1;
                                idx_reg <= {1'b0, ev_i};
                                state_reg <= S_VREAD;
                            end
                        end
                    endcase
                end
                S_VREAD:
                    state_reg <= S_VCAP;
                S_VCAP:
                begin
                    vframe_reg <= rd_frame;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("ready while result pending");
    a_victim_stat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[15:14] == ST_DONE)
        else $error("victim with bad status");
    a_p_bound: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg <= CW'(FRAME_COUNT)) else $error("target out of range");
endmodule
`default_nettype wire
